>>> rtl/lrbf_pkg.sv
// log record block framer: shared constants, result word type and crc helpers
// no dependencies; used by log_record_block_framer_core
package lrbf_pkg;

    localparam int BLK_BITS     = 15;
    localparam int BLOCK_BYTES  = 1 << BLK_BITS;
    localparam int OFF_W        = BLK_BITS + 1;
    localparam int HEADER_BYTES = 7;
    localparam int POS_W        = 48;
    localparam int IDX_W        = POS_W - BLK_BITS;
    localparam int CNT_W        = 16;
    localparam int MAX_RES      = 3;
    localparam int RES_CNT_W    = 2;
    localparam int NUM_TYPES    = 4;

    localparam logic [31:0] CRC_POLY       = 32'h82F63B78;
    localparam logic [31:0] CRC_MASK_DELTA = 32'ha282ead8;

    typedef enum logic [1:0]
    {
        KIND_BYTE   = 2'd0,
        KIND_HEADER = 2'd1,
        KIND_PAD    = 2'd2
    } kind_t;

    typedef enum logic [2:0]
    {
        TYPE_NONE   = 3'd0,
        TYPE_FULL   = 3'd1,
        TYPE_FIRST  = 3'd2,
        TYPE_MIDDLE = 3'd3,
        TYPE_LAST   = 3'd4
    } rec_type_t;

    typedef struct packed
    {
        kind_t            kind;
        logic [POS_W-1:0] pos;
        logic [7:0]       data;
        logic [31:0]      crc;
        logic [14:0]      len;
        rec_type_t        rtype;
        logic [2:0]       pad;
        logic             last;
    } result_t;

    // one reflected crc32c byte step
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  b);
        logic [31:0] r;
        r = crc_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
        end
        return r;
    endfunction

    // running register after the type byte, fresh fragment
    function automatic logic [31:0] type_seed(input int t);
        return crc_byte(32'hFFFFFFFF, 8'(t + 1));
    endfunction

    function automatic logic [31:0] mask_crc(input logic [31:0] c);
        return {c[14:0], c[31:15]} + CRC_MASK_DELTA;
    endfunction

endpackage

>>> rtl/log_record_block_framer_core.sv
// log record block framer top level: input stage, framing logic, result buffer
// depends on lrbf_pkg
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata byte_value, tuser has_byte,
//                                               tlast record_end
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata position/byte/crc/len/type/pad,
//                                               tuser item_kind, tlast last
//  cfg       in   cfg_valid/cfg_ready           cfg_data start_length
//
// an accepted word passes the input register and then the result buffer on its way to m_axis
// one result word per cycle while m_axis_tready is high; a word giving one result keeps
// one word per cycle, a word giving more holds the input until the result buffer drains
// reset clears the offsets and a cfg write reloads them from start_length; no clearing pass
// a stall on m_axis backs up through the buffer and the input register
module log_record_block_framer_core
    import lrbf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [7:0]    s_axis_tdata,   // byte_value
    input  logic          s_axis_tuser,   // has_byte
    input  logic          s_axis_tlast,   // record_end
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [111:0]  m_axis_tdata,   // file_position, data_byte, masked_crc,
                                          // payload_len, record_type, pad_count
    output logic [1:0]    m_axis_tuser,   // item_kind
    output logic          m_axis_tlast,   // last
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [47:0]   cfg_data        // start_length
);

    localparam logic [OFF_W-1:0] OFF_BLOCK = OFF_W'(BLOCK_BYTES);
    localparam logic [OFF_W-1:0] OFF_HDR   = OFF_W'(HEADER_BYTES);
    localparam logic [OFF_W-1:0] OFF_NOPAD = OFF_W'(BLOCK_BYTES - HEADER_BYTES);

    // input stage
    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_has_reg;
    logic        s1_end_reg;

    // framing state
    logic [OFF_W-1:0]            off_reg,  off_next;
    logic [IDX_W-1:0]            blk_reg,  blk_next;
    logic [OFF_W-1:0]            fs_reg,   fs_next;
    logic [CNT_W-1:0]            cnt_reg,  cnt_next;
    logic                        open_reg, open_next;
    logic                        rb_reg,   rb_next;
    logic [NUM_TYPES-1:0][31:0]  run_reg,  run_next;

    // result buffer
    result_t                 res_reg [MAX_RES];
    result_t                 res_next [MAX_RES];
    logic [RES_CNT_W-1:0]    res_cnt_reg;
    logic [RES_CNT_W-1:0]    n_next;

    logic load_ok;
    logic load;
    logic take;
    logic [OFF_W-1:0] leftover;

    assign load_ok       = (res_cnt_reg == '0) || (res_cnt_reg == RES_CNT_W'(1) && m_axis_tready);
    assign load          = s1_valid_reg && load_ok;
    assign take          = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || load_ok;
    assign cfg_ready     = 1'b1;

    function automatic result_t header_item(input logic                       rb,
                                            input logic                       fin,
                                            input logic [NUM_TYPES-1:0][31:0] run,
                                            input logic [CNT_W-1:0]           cnt,
                                            input logic [IDX_W-1:0]           blk,
                                            input logic [OFF_W-1:0]           fs);
        result_t   r;
        rec_type_t t;
        logic [31:0] c;
        r = '0;
        if (rb)
        begin
            t = fin ? TYPE_FULL : TYPE_FIRST;
        end
        else
        begin
            t = fin ? TYPE_LAST : TYPE_MIDDLE;
        end
        case (t)
            TYPE_FULL:   c = run[0];
            TYPE_FIRST:  c = run[1];
            TYPE_MIDDLE: c = run[2];
            TYPE_LAST:   c = run[3];
            default:     c = run[0];
        endcase
        r.kind  = KIND_HEADER;
        r.pos   = {blk, fs[BLK_BITS-1:0]};
        r.crc   = mask_crc(c ^ 32'hFFFFFFFF);
        r.len   = cnt[14:0];
        r.rtype = t;
        return r;
    endfunction

    always_comb
    begin
        off_next  = off_reg;
        blk_next  = blk_reg;
        fs_next   = fs_reg;
        cnt_next  = cnt_reg;
        open_next = open_reg;
        rb_next   = rb_reg;
        run_next  = run_reg;
        n_next    = '0;
        leftover  = OFF_BLOCK - off_reg;
        for (int i = 0; i < MAX_RES; i++)
        begin
            res_next[i] = '0;
        end

        // open a fragment, padding a block tail too short for a header
        if ((s1_has_reg || s1_end_reg) && !open_reg)
        begin
            if (off_next > OFF_NOPAD)
            begin
                if (off_next != OFF_BLOCK)
                begin
                    res_next[n_next].kind = KIND_PAD;
                    res_next[n_next].pos  = {blk_next, off_next[BLK_BITS-1:0]};
                    res_next[n_next].pad  = leftover[2:0];
                    n_next = n_next + RES_CNT_W'(1);
                end
                blk_next = blk_next + IDX_W'(1);
                off_next = '0;
            end
            fs_next  = off_next;
            off_next = off_next + OFF_HDR;
            cnt_next = '0;
            for (int t = 0; t < NUM_TYPES; t++)
            begin
                run_next[t] = type_seed(t);
            end
            open_next = 1'b1;
        end

        if (s1_has_reg)
        begin
            // header filled the block: zero length fragment, continue in next block
            if (off_next >= OFF_BLOCK)
            begin
                res_next[n_next] = header_item(rb_next, 1'b0, run_next, cnt_next,
                                               blk_next, fs_next);
                n_next   = n_next + RES_CNT_W'(1);
                rb_next  = 1'b0;
                blk_next = blk_next + IDX_W'(1);
                fs_next  = '0;
                off_next = OFF_HDR;
                cnt_next = '0;
                for (int t = 0; t < NUM_TYPES; t++)
                begin
                    run_next[t] = type_seed(t);
                end
            end
            res_next[n_next].kind = KIND_BYTE;
            res_next[n_next].pos  = {blk_next, off_next[BLK_BITS-1:0]};
            res_next[n_next].data = s1_byte_reg;
            n_next = n_next + RES_CNT_W'(1);
            for (int t = 0; t < NUM_TYPES; t++)
            begin
                run_next[t] = crc_byte(run_next[t], s1_byte_reg);
            end
            off_next = off_next + OFF_W'(1);
            cnt_next = cnt_next + CNT_W'(1);
            if (s1_end_reg || off_next >= OFF_BLOCK)
            begin
                res_next[n_next] = header_item(rb_next, s1_end_reg, run_next, cnt_next,
                                               blk_next, fs_next);
                n_next    = n_next + RES_CNT_W'(1);
                open_next = 1'b0;
                rb_next   = s1_end_reg;
            end
        end
        else if (s1_end_reg)
        begin
            res_next[n_next] = header_item(rb_next, 1'b1, run_next, cnt_next,
                                           blk_next, fs_next);
            n_next    = n_next + RES_CNT_W'(1);
            open_next = 1'b0;
            rb_next   = 1'b1;
        end

        if (n_next != '0)
        begin
            res_next[n_next - RES_CNT_W'(1)].last = 1'b1;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_axis_tvalid && s_axis_tready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (load)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            s1_byte_reg <= s_axis_tdata;
            s1_has_reg  <= s_axis_tuser;
            s1_end_reg  <= s_axis_tlast;
        end
    end

    // framing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg  <= '0;
            blk_reg  <= '0;
            fs_reg   <= '0;
            cnt_reg  <= '0;
            open_reg <= 1'b0;
            rb_reg   <= 1'b1;
            run_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            off_reg  <= {1'b0, cfg_data[BLK_BITS-1:0]};
            blk_reg  <= cfg_data[POS_W-1:BLK_BITS];
            fs_reg   <= '0;
            cnt_reg  <= '0;
            open_reg <= 1'b0;
            rb_reg   <= 1'b1;
        end
        else if (load)
        begin
            off_reg  <= off_next;
            blk_reg  <= blk_next;
            fs_reg   <= fs_next;
            cnt_reg  <= cnt_next;
            open_reg <= open_next;
            rb_reg   <= rb_next;
            run_reg  <= run_next;
        end
    end

    // result buffer, drained from entry 0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_cnt_reg <= '0;
        end
        else if (load)
        begin
            res_cnt_reg <= n_next;
        end
        else if (take)
        begin
            res_cnt_reg <= res_cnt_reg - RES_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < MAX_RES; i++)
            begin
                res_reg[i] <= res_next[i];
            end
        end
        else if (take)
        begin
            for (int i = 0; i < MAX_RES - 1; i++)
            begin
                res_reg[i] <= res_reg[i+1];
            end
        end
    end

    assign m_axis_tvalid = (res_cnt_reg != '0);
    assign m_axis_tuser  = res_reg[0].kind;
    assign m_axis_tlast  = res_reg[0].last;
    assign m_axis_tdata  = {3'd0, res_reg[0].pad, res_reg[0].rtype, res_reg[0].len,
                            res_reg[0].crc, res_reg[0].data, res_reg[0].pos};

    // last word of a group is the final buffered entry
    a_last_final: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> res_cnt_reg == RES_CNT_W'(1))
        else $error("last flag on a word that is not the final buffered entry");

    // a padding run is never the final word and holds at least one byte
    a_pad_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_PAD |-> !m_axis_tlast && res_reg[0].pad != 3'd0)
        else $error("malformed padding word");

    // an open fragment never sits at the end of a block
    a_open_room: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg |-> off_reg < OFF_BLOCK)
        else $error("open fragment with a full block");

    // offset tracks fragment start, header and payload count
    a_open_offset: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg |-> {1'b0, off_reg} == {1'b0, fs_reg} + {1'b0, OFF_HDR} + {1'b0, cnt_reg})
        else $error("block offset out of step with fragment length");

    // an idle input step produces no words
    a_idle_step: assert property (@(posedge clk) disable iff (!rst_n)
        load && !s1_has_reg && !s1_end_reg |=> res_cnt_reg == '0)
        else $error("idle step produced output");

endmodule
